[sv/ppr_pkg.sv]
// Shared types, constants and fixed-point helpers for the point projection unit.
// No dependencies; imported by every module of the block.
package ppr_pkg;

  localparam int QB        = 24;  // fraction bits of the Q8.24 intermediates
  localparam int FRAC_BITS = 16;  // fraction bits of points and intrinsics
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int PIPE_LAT  = 2 * DIV_LAT + 9;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DEPTH_ZERO = 2'd1,
    ST_DEN_ZERO   = 2'd2,
    ST_SAT        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTRE_X = 3'd2,
    REG_CENTRE_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] q;
    logic               sat;
  } div_res_t;

  typedef struct packed {
    logic signed [15:0] u;
    logic signed [15:0] v;
    status_t            st;
  } pix_res_t;

  // Divide by 2^QB, rounding toward zero.
  function automatic logic signed [64-QB:0] tdiv_q(input logic signed [64:0] p);
    logic signed [64:0] b;
    b = p + (p[64] ? ((65'sd1 <<< QB) - 65'sd1) : 65'sd0);
    return b[64:QB];
  endfunction

  // Clamp to 32-bit signed and flag the clamp.
  function automatic div_res_t sat32(input logic signed [41:0] v);
    div_res_t r;
    if (v > 42'sd2147483647) begin
      r.q   = 32'sh7fffffff;
      r.sat = 1'b1;
    end else if (v < -42'sd2147483648) begin
      r.q   = 32'sh80000000;
      r.sat = 1'b1;
    end else begin
      r.q   = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

[sv/ppr_div.sv]
// Pipelined signed Q8.24 divider: (num * 2^24) / den, toward zero, saturated.
// One restoring step per stage; depends on ppr_pkg.
module ppr_div import ppr_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output div_res_t           res
);

  logic [31:0] an, ad;
  logic [31:0] rem  [DIV_STEPS+1];
  logic [7:0]  low  [DIV_STEPS+1];
  logic [31:0] quo  [DIV_STEPS+1];
  logic [31:0] dv   [DIV_STEPS+1];
  logic        neg  [DIV_STEPS+1];
  logic        ovf  [DIV_STEPS+1];

  assign an = num[31] ? -num : num;
  assign ad = den[31] ? -den : den;

  // Quotient of 2^32 or more saturates regardless of sign.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {8'd0, an[31:8]};
      low[0] <= an[7:0];
      quo[0] <= '0;
      dv[0]  <= ad;
      neg[0] <= num[31] ^ den[31];
      ovf[0] <= (ad[31:24] == 8'd0) ? (an >= {ad[23:0], 8'd0}) : 1'b0;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [32:0] t;
    logic [32:0] diff;
    logic        ge;
    assign t    = {rem[k-1], low[k-1][7]};
    assign diff = t - {1'b0, dv[k-1]};
    assign ge   = t >= {1'b0, dv[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[31:0] : t[31:0];
        low[k] <= {low[k-1][6:0], 1'b0};
        quo[k] <= {quo[k-1][30:0], ge};
        dv[k]  <= dv[k-1];
        neg[k] <= neg[k-1];
        ovf[k] <= ovf[k-1];
      end
    end
  end

  logic [31:0] qf;
  logic        sf;
  assign qf = quo[DIV_STEPS];

  always_comb begin
    if (neg[DIV_STEPS]) begin
      sf = ovf[DIV_STEPS] || (qf[31] && (qf[30:0] != 31'd0));
    end else begin
      sf = ovf[DIV_STEPS] || qf[31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.sat <= sf;
      if (sf) begin
        res.q <= neg[DIV_STEPS] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        res.q <= neg[DIV_STEPS] ? -qf : qf;
      end
    end
  end

endmodule

[sv/ppr_outq.sv]
// Two-entry result queue that parts the pipeline from the output handshake.
// Depends on ppr_pkg for the result type.
module ppr_outq import ppr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pix_res_t din,
  input  logic     pop,
  output pix_res_t dout,
  output logic     nonempty,
  output logic     full
);

  pix_res_t    mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full result queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("pop from empty result queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");

endmodule

[sv/point_projection_radial_distortion_unit.sv]
// Top level of the point projection unit with rational radial distortion.
// Depends on ppr_pkg, ppr_div and ppr_outq.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, point_x/y/z            item in
//   out       out_valid/out_ready, pixel_u/v, status    item out
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  register write
//
// One item per cycle while the result queue is not full; latency is set by two
// 32-stage restoring dividers in series (x/z with y/z, then the distortion ratio).
// Reset clears the valid line, the result queue and the registers to defaults.
// A stall at out freezes the whole pipeline once the two-entry result queue is
// full; in_ready drops in the same cycle and nothing is lost or repeated.
module point_projection_radial_distortion_unit import ppr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pixel_u,
  output logic signed [15:0] pixel_v,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef struct packed {
    logic signed [31:0] xp;
    logic signed [31:0] yp;
    logic               z0;
    logic               den0;
    logic               sat;
  } side_t;

  logic [31:0]        focal_x, focal_y, centre_x, centre_y;
  logic signed [31:0] k1_coeff, k2_coeff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= 32'd32768000;
      focal_y  <= 32'd32768000;
      centre_x <= 32'd20971520;
      centre_y <= 32'd15728640;
      k1_coeff <= '0;
      k2_coeff <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:  focal_x  <= cfg_data;
        REG_FOCAL_Y:  focal_y  <= cfg_data;
        REG_CENTRE_X: centre_x <= cfg_data;
        REG_CENTRE_Y: centre_y <= cfg_data;
        REG_K1:       k1_coeff <= cfg_data;
        REG_K2:       k2_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                en;
  logic                q_full;
  logic [PIPE_LAT-1:0] vld;

  assign en       = !q_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // Normalize by depth.
  div_res_t           divx, divy, divd;
  logic [DIV_LAT-1:0] z0_line;

  ppr_div u_div_x (.clk(clk), .en(en), .num(point_x), .den(point_z), .res(divx));
  ppr_div u_div_y (.clk(clk), .en(en), .num(point_y), .den(point_z), .res(divy));

  always_ff @(posedge clk) begin
    if (en) begin
      z0_line <= {z0_line[DIV_LAT-2:0], point_z == 32'sd0};
    end
  end

  // Squares, then r2, then the products k1*r2 and k2*r2.
  logic signed [31:0] xp1, yp1, xp2, yp2, xp3, yp3, xp4, yp4;
  logic signed [63:0] sqx, sqy;
  logic               z0_1, z0_2, z0_3, z0_4;
  logic               sat1, sat2, sat3, sat4;
  logic [39:0]        r2s;
  logic signed [31:0] r2;
  logic signed [63:0] pk1, pk2;
  logic signed [31:0] num4, den4;
  logic               den0_4;
  div_res_t           num_c, den_c;

  assign r2s = {1'b0, sqx[62:QB]} + {1'b0, sqy[62:QB]};

  always_ff @(posedge clk) begin
    if (en) begin
      xp1  <= divx.q;
      yp1  <= divy.q;
      sqx  <= divx.q * divx.q;
      sqy  <= divy.q * divy.q;
      z0_1 <= z0_line[DIV_LAT-1];
      sat1 <= divx.sat | divy.sat;

      xp2  <= xp1;
      yp2  <= yp1;
      z0_2 <= z0_1;
      r2   <= (r2s > 40'h007fffffff) ? 32'sh7fffffff : r2s[31:0];
      sat2 <= sat1 | (r2s > 40'h007fffffff);

      xp3  <= xp2;
      yp3  <= yp2;
      z0_3 <= z0_2;
      sat3 <= sat2;
      pk1  <= k1_coeff * r2;
      pk2  <= k2_coeff * r2;
    end
  end

  // Numerator and denominator of the distortion ratio.
  always_comb begin
    num_c = sat32((42'sd1 <<< QB) + 42'(tdiv_q({pk1[63], pk1})));
    den_c = sat32((42'sd1 <<< QB) + 42'(tdiv_q({pk2[63], pk2})));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp4    <= xp3;
      yp4    <= yp3;
      z0_4   <= z0_3;
      num4   <= num_c.q;
      den4   <= den_c.q;
      den0_4 <= den_c.q == 32'sd0;
      sat4   <= sat3 | num_c.sat | den_c.sat;
    end
  end

  // Distortion ratio; carry the rest alongside.
  side_t side_line [DIV_LAT];
  side_t sd;

  ppr_div u_div_d (.clk(clk), .en(en), .num(num4), .den(den4), .res(divd));

  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0] <= '{xp: xp4, yp: yp4, z0: z0_4, den0: den0_4, sat: sat4};
      for (int i = 1; i < DIV_LAT; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  assign sd = side_line[DIV_LAT-1];

  // Apply the ratio, then the intrinsics.
  logic signed [63:0] mx, my;
  side_t              s5, s6, s7, s8;
  div_res_t           qx_c, qy_c;
  logic signed [31:0] qx, qy;
  logic signed [64:0] fpx, fpy;
  logic signed [41:0] fx, fy;

  always_comb begin
    qx_c = sat32(42'(tdiv_q({mx[63], mx})));
    qy_c = sat32(42'(tdiv_q({my[63], my})));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5     <= '{xp: sd.xp, yp: sd.yp, z0: sd.z0, den0: sd.den0,
                  sat: sd.sat | divd.sat};
      mx     <= sd.xp * divd.q;
      my     <= sd.yp * divd.q;

      s6     <= '{xp: s5.xp, yp: s5.yp, z0: s5.z0, den0: s5.den0,
                  sat: s5.sat | qx_c.sat | qy_c.sat};
      qx     <= qx_c.q;
      qy     <= qy_c.q;

      s7     <= s6;
      fpx    <= $signed({1'b0, focal_x}) * qx;
      fpy    <= $signed({1'b0, focal_y}) * qy;

      s8     <= s7;
      fx     <= 42'(tdiv_q(fpx)) + $signed({10'd0, centre_x});
      fy     <= 42'(tdiv_q(fpy)) + $signed({10'd0, centre_y});
    end
  end

  // Integer pixel, toward zero, clamped to 16 bits.
  logic signed [41:0] gx_b, gy_b;
  logic signed [41-FRAC_BITS:0] gx, gy;
  logic               cx, cy;
  logic signed [15:0] ux, vy;
  pix_res_t           res9;

  always_comb begin
    gx_b = fx + (fx[41] ? ((42'sd1 <<< FRAC_BITS) - 42'sd1) : 42'sd0);
    gy_b = fy + (fy[41] ? ((42'sd1 <<< FRAC_BITS) - 42'sd1) : 42'sd0);
    gx   = gx_b[41:FRAC_BITS];
    gy   = gy_b[41:FRAC_BITS];
    cx   = (gx > 32767) || (gx < -32768);
    cy   = (gy > 32767) || (gy < -32768);
    ux   = (gx > 32767) ? 16'sh7fff : (gx < -32768) ? 16'sh8000 : gx[15:0];
    vy   = (gy > 32767) ? 16'sh7fff : (gy < -32768) ? 16'sh8000 : gy[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (s8.z0) begin
        res9 <= '{u: '0, v: '0, st: ST_DEPTH_ZERO};
      end else if (s8.den0) begin
        res9 <= '{u: '0, v: '0, st: ST_DEN_ZERO};
      end else begin
        res9 <= '{u: ux, v: vy, st: (s8.sat | cx | cy) ? ST_SAT : ST_OK};
      end
    end
  end

  pix_res_t qout;

  ppr_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (en && vld[PIPE_LAT-1]),
    .din     (res9),
    .pop     (out_valid && out_ready),
    .dout    (qout),
    .nonempty(out_valid),
    .full    (q_full)
  );

  assign pixel_u = qout.u;
  assign pixel_v = qout.v;
  assign status  = qout.st;

  a_frozen: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && (status == ST_DEPTH_ZERO || status == ST_DEN_ZERO)
      |-> pixel_u == 16'sd0 && pixel_v == 16'sd0)
    else $error("nonzero pixel on error status");
  a_stall_held: assert property (@(posedge clk) disable iff (rst) !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule
